@@ sv/bcf_pkg.sv @@
// Shared types and constants for the byte-stuffed checksum framer.
// No dependencies; imported by every module of the block.
package bcf_pkg;

    localparam int START_REPEAT_DEF = 2;
    localparam int QUEUE_DEPTH      = 2;
    localparam int CFG_ADDR_W       = 3;

    localparam logic [7:0] START_BYTE_RST  = 8'hAA;
    localparam logic [7:0] ESCAPE_BYTE_RST = 8'hFF;

    localparam logic CFG_IDX_START  = 1'b0;
    localparam logic CFG_IDX_ESCAPE = 1'b1;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       data_esc;
        logic [7:0] sum;
        logic       sum_esc;
    } job_t;

endpackage

@@ sv/bcf_front.sv @@
// Front part: running checksum and escape classification of each item.
// Depends on bcf_pkg (job_t).
module bcf_front
    import bcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] data_byte,
    input  logic       first_byte,
    input  logic       last_byte,
    input  logic [7:0] start_byte,
    input  logic [7:0] escape_byte,
    output job_t       job
);

    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [7:0] sum_base;
    logic [7:0] sum_new;

    always_comb
    begin
        sum_base = first_byte ? 8'h00 : sum_reg;
        sum_new  = sum_base + data_byte;
        sum_next = sum_reg;
        if (push)
        begin
            sum_next = last_byte ? 8'h00 : sum_new;
        end
        job.data     = data_byte;
        job.first    = first_byte;
        job.last     = last_byte;
        job.data_esc = (data_byte == start_byte) || (data_byte == escape_byte);
        job.sum      = sum_new;
        job.sum_esc  = (sum_new == start_byte) || (sum_new == escape_byte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= 8'h00;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

endmodule

@@ sv/bcf_queue.sv @@
// Two-entry queue of classified items between front and back parts.
// Depends on bcf_pkg (job_t, QUEUE_DEPTH).
module bcf_queue
    import bcf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic not_full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign not_full   = count_reg != CNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ sv/bcf_back.sv @@
// Back part: expands queued items to bytes, one per unstalled cycle.
// Depends on bcf_pkg (job_t); drives the registered output channel.
module bcf_back
    import bcf_pkg::*;
#(
    parameter int START_REPEAT = START_REPEAT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  job_t       q_job,
    output logic       q_pop,
    input  logic [7:0] start_byte,
    input  logic [7:0] escape_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_end,
    output logic       frame_end
);

    localparam int CNT_W = (START_REPEAT > 1) ? $clog2(START_REPEAT) : 1;

    typedef enum logic [2:0] {
        PH_NEW,
        PH_START,
        PH_DATA,
        PH_DATA_CPL,
        PH_SUM,
        PH_SUM_CPL
    } phase_t;

    phase_t           phase_reg;
    phase_t           phase_next;
    phase_t           phase_cur;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             run_end_reg;
    logic             frame_end_reg;
    logic [7:0]       byte_sel;
    logic             done_sel;
    logic             frame_sel;
    logic             advance;

    assign advance   = q_valid && (!out_valid_reg || out_ready);
    assign q_pop     = advance && done_sel;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_end   = run_end_reg;
    assign frame_end = frame_end_reg;

    always_comb
    begin
        if (phase_reg == PH_NEW)
        begin
            phase_cur = q_job.first ? PH_START : PH_DATA;
        end
        else
        begin
            phase_cur = phase_reg;
        end
        byte_sel   = q_job.data;
        done_sel   = 1'b0;
        frame_sel  = 1'b0;
        phase_next = phase_cur;
        cnt_next   = cnt_reg;
        unique case (phase_cur)
            PH_START:
            begin
                byte_sel = start_byte;
                if (cnt_reg == CNT_W'(START_REPEAT - 1))
                begin
                    cnt_next   = '0;
                    phase_next = PH_DATA;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            PH_DATA:
            begin
                if (q_job.data_esc)
                begin
                    byte_sel   = escape_byte;
                    phase_next = PH_DATA_CPL;
                end
                else
                begin
                    byte_sel   = q_job.data;
                    phase_next = PH_SUM;
                    done_sel   = !q_job.last;
                end
            end
            PH_DATA_CPL:
            begin
                byte_sel   = ~q_job.data;
                phase_next = PH_SUM;
                done_sel   = !q_job.last;
            end
            PH_SUM:
            begin
                if (q_job.sum_esc)
                begin
                    byte_sel   = escape_byte;
                    phase_next = PH_SUM_CPL;
                end
                else
                begin
                    byte_sel  = q_job.sum;
                    done_sel  = 1'b1;
                    frame_sel = 1'b1;
                end
            end
            PH_SUM_CPL:
            begin
                byte_sel  = ~q_job.sum;
                done_sel  = 1'b1;
                frame_sel = 1'b1;
            end
            default:
            begin
                byte_sel = q_job.data;
            end
        endcase
        if (done_sel)
        begin
            phase_next = PH_NEW;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_NEW;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= 8'h00;
            run_end_reg   <= 1'b0;
            frame_end_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg     <= phase_next;
                cnt_reg       <= cnt_next;
                out_valid_reg <= 1'b1;
                out_byte_reg  <= byte_sel;
                run_end_reg   <= done_sel;
                frame_end_reg <= frame_sel;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_frame_end_closes_run : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && frame_end_reg |-> run_end_reg)
        else $error("frame end without run end");

    a_mid_item_holds_job : assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_NEW |-> q_valid)
        else $error("item in progress without a queued job");

    a_pop_loads_run_end : assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> out_valid_reg && run_end_reg)
        else $error("pop without a run end byte");

    a_new_after_pop : assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> phase_reg == PH_NEW && cnt_reg == '0)
        else $error("phase not restarted after pop");
`endif

endmodule

@@ sv/byte_stuffed_checksum_framer_top.sv @@
// Top level of the byte-stuffed checksum framer: APB registers and wiring.
// Depends on bcf_pkg, bcf_front, bcf_queue and bcf_back.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------------
//   in       | in_valid / in_ready   | data_byte, first_byte, last_byte
//   out      | out_valid / out_ready | out_byte, run_end, frame_end
//   cfg      | psel/penable/pwrite   | paddr, pwdata, prdata
//
// One wire byte leaves per cycle from the back part's sequencer while the
// output is not stalled; an item produces 1 to START_REPEAT + 4 wire bytes.
// Items enter every cycle while the two-entry queue has room.
// Reset clears checksum, queue and sequencer; registers get their defaults.
// A stalled output holds its byte while the front keeps filling the queue.
module byte_stuffed_checksum_framer_top
    import bcf_pkg::*;
#(
    parameter int START_REPEAT = START_REPEAT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            data_byte,
    input  logic                  first_byte,
    input  logic                  last_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  run_end,
    output logic                  frame_end,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [7:0] start_byte_reg;
    logic [7:0] escape_byte_reg;
    logic       cfg_wr;
    logic       push;
    logic       q_pop;
    logic       q_valid;
    job_t       push_job;
    job_t       q_job;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == CFG_IDX_ESCAPE) ? {24'h0, escape_byte_reg}
                                                 : {24'h0, start_byte_reg};
    assign push   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg  <= START_BYTE_RST;
            escape_byte_reg <= ESCAPE_BYTE_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == CFG_IDX_START)
            begin
                start_byte_reg <= pwdata[7:0];
            end
            else
            begin
                escape_byte_reg <= pwdata[7:0];
            end
        end
    end

    bcf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .data_byte   (data_byte),
        .first_byte  (first_byte),
        .last_byte   (last_byte),
        .start_byte  (start_byte_reg),
        .escape_byte (escape_byte_reg),
        .job         (push_job)
    );

    bcf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .not_full   (in_ready),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (q_job)
    );

    bcf_back #(
        .START_REPEAT (START_REPEAT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_job       (q_job),
        .q_pop       (q_pop),
        .start_byte  (start_byte_reg),
        .escape_byte (escape_byte_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .run_end     (run_end),
        .frame_end   (frame_end)
    );

endmodule
